// ----- sv/u8d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// types, codes and table functions shared by the utf-8 decoder files
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CP_W  = 21;
  localparam int ST_W  = 4;
  localparam int CLS_W = 4;

  typedef logic [ST_W-1:0]  dfa_state_t;
  typedef logic [CLS_W-1:0] byte_class_t;
  typedef logic [CP_W-1:0]  code_point_t;

  localparam dfa_state_t DFA_ACCEPT = 4'd0;
  localparam dfa_state_t DFA_REJECT = 4'd1;
  localparam dfa_state_t DFA_S2     = 4'd2;
  localparam dfa_state_t DFA_S3     = 4'd3;
  localparam dfa_state_t DFA_S4     = 4'd4;
  localparam dfa_state_t DFA_S5     = 4'd5;
  localparam dfa_state_t DFA_S6     = 4'd6;
  localparam dfa_state_t DFA_S7     = 4'd7;
  localparam dfa_state_t DFA_S8     = 4'd8;

  // character classes
  localparam byte_class_t CLS_ASCII    = 4'd0;
  localparam byte_class_t CLS_CONT_8X  = 4'd1;
  localparam byte_class_t CLS_LEAD2    = 4'd2;
  localparam byte_class_t CLS_LEAD3    = 4'd3;
  localparam byte_class_t CLS_LEAD_ED  = 4'd4;
  localparam byte_class_t CLS_LEAD_F4  = 4'd5;
  localparam byte_class_t CLS_LEAD4    = 4'd6;
  localparam byte_class_t CLS_CONT_AB  = 4'd7;
  localparam byte_class_t CLS_BAD      = 4'd8;
  localparam byte_class_t CLS_CONT_9X  = 4'd9;
  localparam byte_class_t CLS_LEAD_E0  = 4'd10;
  localparam byte_class_t CLS_LEAD_F0  = 4'd11;

  typedef enum logic [1:0] {
    STATUS_MORE    = 2'd0,
    STATUS_DONE    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    dfa_state_t  state;
    code_point_t acc;
    code_point_t code_point;
    status_t     status;
  } step_result_t;

  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t c;
    if (b < 8'h80)       c = CLS_ASCII;
    else if (b < 8'h90)  c = CLS_CONT_8X;
    else if (b < 8'hA0)  c = CLS_CONT_9X;
    else if (b < 8'hC0)  c = CLS_CONT_AB;
    else if (b < 8'hC2)  c = CLS_BAD;
    else if (b < 8'hE0)  c = CLS_LEAD2;
    else if (b == 8'hE0) c = CLS_LEAD_E0;
    else if (b == 8'hED) c = CLS_LEAD_ED;
    else if (b < 8'hF0)  c = CLS_LEAD3;
    else if (b == 8'hF0) c = CLS_LEAD_F0;
    else if (b < 8'hF4)  c = CLS_LEAD4;
    else if (b == 8'hF4) c = CLS_LEAD_F4;
    else                 c = CLS_BAD;
    return c;
  endfunction

  function automatic dfa_state_t next_state(input dfa_state_t s, input byte_class_t c);
    dfa_state_t n;
    logic       c1, c7, c9;
    c1 = (c == CLS_CONT_8X);
    c7 = (c == CLS_CONT_AB);
    c9 = (c == CLS_CONT_9X);
    n  = DFA_REJECT;
    case (s)
      DFA_ACCEPT: begin
        case (c)
          CLS_ASCII:   n = DFA_ACCEPT;
          CLS_LEAD2:   n = DFA_S2;
          CLS_LEAD3:   n = DFA_S3;
          CLS_LEAD_ED: n = DFA_S5;
          CLS_LEAD_F4: n = DFA_S8;
          CLS_LEAD4:   n = DFA_S7;
          CLS_LEAD_E0: n = DFA_S4;
          CLS_LEAD_F0: n = DFA_S6;
          default:     n = DFA_REJECT;
        endcase
      end
      DFA_S2: if (c1 || c7 || c9) n = DFA_ACCEPT;
      DFA_S3: if (c1 || c7 || c9) n = DFA_S2;
      DFA_S4: if (c7) n = DFA_S2;
      DFA_S5: if (c1 || c9) n = DFA_S2;
      DFA_S6: if (c7 || c9) n = DFA_S3;
      DFA_S7: if (c1 || c7 || c9) n = DFA_S3;
      DFA_S8: if (c1) n = DFA_S3;
      default: n = DFA_REJECT;  // reject state sticks; unused codes go to reject
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- sv/u8d_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_in_if
// byte channel into the decoder
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       text_start;

  modport source (output valid, output data_byte, output text_start, input ready);
  modport sink   (input valid, input data_byte, input text_start, output ready);
endinterface
`default_nettype wire

// ----- sv/u8d_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_if
// result channel out of the decoder
// ----------------------------------------------------------------------------
interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;

  modport source (output valid, output code_point, output status, input ready);
  modport sink   (input valid, input code_point, input status, output ready);
endinterface
`default_nettype wire

// ----- sv/u8d_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_step
// one automaton step: classify byte, update accumulator and state
// ----------------------------------------------------------------------------
module u8d_step import u8d_pkg::*; (
  input  dfa_state_t   state,
  input  code_point_t  acc,
  input  logic [7:0]   data_byte,
  input  logic         text_start,
  output step_result_t res
);

  dfa_state_t  st_eff;
  code_point_t acc_eff;
  byte_class_t cls;
  logic [7:0]  lead_mask;
  dfa_state_t  st_new;
  code_point_t acc_new;

  always_comb begin
    // text start restarts decoding before this byte
    st_eff    = text_start ? DFA_ACCEPT : state;
    acc_eff   = text_start ? '0 : acc;
    cls       = byte_class(data_byte);
    lead_mask = 8'hFF >> cls;
    if (st_eff == DFA_ACCEPT) begin
      acc_new = {{(CP_W-8){1'b0}}, lead_mask & data_byte};
    end else begin
      acc_new = {acc_eff[CP_W-7:0], data_byte[5:0]};
    end
    st_new = next_state(st_eff, cls);

    res.state      = st_new;
    res.acc        = acc_new;
    res.code_point = '0;
    if (st_new == DFA_ACCEPT) begin
      res.status     = STATUS_DONE;
      res.code_point = acc_new;
    end else if (st_new == DFA_REJECT) begin
      res.status = STATUS_INVALID;
    end else begin
      res.status = STATUS_MORE;
    end
  end

endmodule
`default_nettype wire

// ----- sv/utf8_byte_stream_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top
// streaming utf-8 decoder, one byte in and one result out per beat
// ----------------------------------------------------------------------------
// Every accepted byte beat yields exactly one result beat: status 0 means
// more bytes are needed, 1 means a code point is complete (code_point holds
// it, otherwise code_point is zero), 2 means the sequence is invalid. The
// invalid state holds until a byte arrives with text_start set, which
// restarts the automaton before that byte is decoded. Throughput is one byte
// per clock unless out_chan.ready holds it off; each beat passes through the
// input register and then the result register. The rate is set by the
// state feedback loop: classifier, next-state table and accumulator shift
// sit between the input register and the result register, and the state
// registers update in the same cycle the result is captured.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_top import u8d_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  u8d_in_if.sink      in_chan,
  u8d_out_if.source   out_chan
);

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;

  // automaton state
  dfa_state_t  dfa_state_r;
  code_point_t acc_r;

  // result register
  logic        out_valid_r;
  code_point_t out_cp_r;
  status_t     out_status_r;

  step_result_t step_res;
  logic         s1_advance;
  logic         in_take;

  // input stage moves on whenever the result register is free or draining
  assign s1_advance = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_advance;
  assign in_take = in_chan.valid && in_chan.ready;

  u8d_step u_step (
    .state      (dfa_state_r),
    .acc        (acc_r),
    .data_byte  (s1_byte_r),
    .text_start (s1_start_r),
    .res        (step_res)
  );

  // control: valids and automaton state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dfa_state_r <= DFA_ACCEPT;
      acc_r       <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
        dfa_state_r <= step_res.state;
        acc_r       <= step_res.acc;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_chan.data_byte;
      s1_start_r <= in_chan.text_start;
    end
    if (s1_advance) begin
      out_cp_r     <= step_res.code_point;
      out_status_r <= step_res.status;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.code_point = out_cp_r;
  assign out_chan.status     = out_status_r;

endmodule
`default_nettype wire

// ----- tb/utf8_byte_stream_decoder_top_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top_test
// self-checking bench for the streaming utf-8 decoder
// ----------------------------------------------------------------------------
// A directed run walks the class extremes: ascii ends, shortest and longest
// two and four byte forms, the shortest three byte form, the E0/ED/F0/F4 leads,
// a bad lead, the sticky invalid state and a restart by text_start. Random
// units follow: mostly well-formed encodings of random code points, plus
// truncated sequences, bad leads with continuations and raw noise. A
// scoreboard keeps its own automaton and checks every result beat in order.
// Both channel sides idle at random, and the receiver holds off once for a
// long stretch so the decoder backs up into its input.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_top_test;
  import u8d_pkg::*;

  localparam int TOTAL_BYTES = 575;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 150;

  typedef struct packed {
    code_point_t code_point;
    status_t     status;
  } decoded_beat_t;

  // decoder model plus the queue of results still owed by the block
  class utf8_decode_scoreboard;
    dfa_state_t    dec_state;
    code_point_t   dec_acc;
    dfa_state_t    step_tab [9][12];
    decoded_beat_t expected_q [$];
    int            mismatches;
    int            n_bytes;
    int            n_restarts;
    int            n_done;
    int            n_invalid;

    function new();
      dec_state  = DFA_ACCEPT;
      dec_acc    = '0;
      mismatches = 0;
      n_bytes    = 0;
      n_restarts = 0;
      n_done     = 0;
      n_invalid  = 0;
      step_tab = '{
        '{0, 1, 2, 3, 5, 8, 7, 1, 1, 1, 4, 6},
        '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1},
        '{1, 0, 1, 1, 1, 1, 1, 0, 1, 0, 1, 1},
        '{1, 2, 1, 1, 1, 1, 1, 2, 1, 2, 1, 1},
        '{1, 1, 1, 1, 1, 1, 1, 2, 1, 1, 1, 1},
        '{1, 2, 1, 1, 1, 1, 1, 1, 1, 2, 1, 1},
        '{1, 1, 1, 1, 1, 1, 1, 3, 1, 3, 1, 1},
        '{1, 3, 1, 1, 1, 1, 1, 3, 1, 3, 1, 1},
        '{1, 3, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1}
      };
    endfunction

    // class by high nibble, then the few single-byte exceptions
    function byte_class_t classify(logic [7:0] b);
      byte_class_t c;
      case (b[7:4])
        4'h8:       c = CLS_CONT_8X;
        4'h9:       c = CLS_CONT_9X;
        4'hA, 4'hB: c = CLS_CONT_AB;
        4'hC:       c = (b[3:1] == 3'b000) ? CLS_BAD : CLS_LEAD2;
        4'hD:       c = CLS_LEAD2;
        4'hE: begin
          if (b == 8'hE0)      c = CLS_LEAD_E0;
          else if (b == 8'hED) c = CLS_LEAD_ED;
          else                 c = CLS_LEAD3;
        end
        4'hF: begin
          if (b == 8'hF0)      c = CLS_LEAD_F0;
          else if (b <= 8'hF3) c = CLS_LEAD4;
          else if (b == 8'hF4) c = CLS_LEAD_F4;
          else                 c = CLS_BAD;
        end
        default:    c = CLS_ASCII;
      endcase
      return c;
    endfunction

    function void note_byte(logic [7:0] b, logic ts);
      byte_class_t   cls;
      dfa_state_t    cur;
      decoded_beat_t beat;
      n_bytes++;
      if (ts) begin
        dec_state = DFA_ACCEPT;
        dec_acc   = '0;
        n_restarts++;
      end
      cur = (dec_state > DFA_S8) ? DFA_REJECT : dec_state;
      cls = classify(b);
      if (cur == DFA_ACCEPT) dec_acc = code_point_t'(b & (8'hFF >> cls));
      else dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
      dec_state = step_tab[cur][cls];
      beat.code_point = '0;
      case (dec_state)
        DFA_ACCEPT: begin
          beat.status     = STATUS_DONE;
          beat.code_point = dec_acc;
        end
        DFA_REJECT: beat.status = STATUS_INVALID;
        default:    beat.status = STATUS_MORE;
      endcase
      expected_q.push_back(beat);
    endfunction

    function void check_result(code_point_t cp, status_t st);
      decoded_beat_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: code_point %h status %0d", cp, st);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (cp !== want.code_point) begin
        $error("code_point mismatch: expected %h actual %h", want.code_point, cp);
        mismatches++;
      end
      if (st !== want.status) begin
        $error("status mismatch: expected %0d actual %0d", want.status, st);
        mismatches++;
      end
      if (want.status == STATUS_DONE) n_done++;
      if (want.status == STATUS_INVALID) n_invalid++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  u8d_in_if  in_if ();
  u8d_out_if out_if ();

  utf8_byte_stream_decoder_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #4 clk = ~clk;

  utf8_decode_scoreboard sb;
  logic burst_mode = 1'b0;   // no idling on either side while set, apart from the long hold-off
  int   beats_out  = 0;
  int   cycles     = 0;

  // directed opening: bit 8 is text_start, low byte is the data
  logic [8:0] directed_seq [0:25] = '{
    9'h100, 9'h07F,                   // restart on nul, top ascii
    9'h0C2, 9'h080, 9'h0DF, 9'h0BF,   // two byte low and high ends
    9'h0E0, 9'h0A0, 9'h080,           // E0 lead, shortest three byte
    9'h0ED, 9'h09F, 9'h0BF,           // ED lead, just below surrogates
    9'h0F0, 9'h090, 9'h080, 9'h080,   // F0 lead, shortest four byte
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,   // F4 lead, highest code point
    9'h0C0, 9'h041, 9'h0FF,           // overlong lead, invalid sticks
    9'h141,                           // text_start clears the invalid state
    9'h0E1, 9'h1F3                    // restart in the middle of a sequence
  };

  // ---------------------------------------------------------------------
  // input side: one beat per call, entered and left just after a falling
  // edge so data never moves near the rising edge
  // ---------------------------------------------------------------------
  function automatic int in_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic ts);
    int gap;
    gap = in_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.data_byte  = b;
    in_if.text_start = ts;
    // beat lands at the first rising edge with ready high
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_byte(b, ts);
    @(negedge clk);
  endtask

  // one unit: a well-formed encoding, a broken one, or noise
  task automatic send_unit();
    int          kind;
    int          len;
    int          n;
    int unsigned lo;
    int unsigned hi;
    code_point_t cp;
    logic [7:0]  seq [4];
    logic        first_ts;
    if ($urandom_range(0, 29) == 0) burst_mode = !burst_mode;
    // leave the invalid state most of the time, restart now and then anyway
    first_ts = ((sb.dec_state == DFA_REJECT) && ($urandom_range(0, 3) != 0)) ||
               ($urandom_range(0, 23) == 0);
    kind = $urandom_range(0, 15);
    if (kind <= 12) begin
      if (kind < 3)       len = 1;
      else if (kind < 6)  len = 2;
      else if (kind < 9)  len = 3;
      else if (kind < 12) len = 4;
      else                len = $urandom_range(2, 4);
      case (len)
        1:       begin lo = 'h0;     hi = 'h7F;     end
        2:       begin lo = 'h80;    hi = 'h7FF;    end
        3:       begin lo = 'h800;   hi = 'hFFFF;   end
        default: begin lo = 'h10000; hi = 'h10FFFF; end
      endcase
      cp = code_point_t'($urandom_range(lo, hi));
      if ($urandom_range(0, 7) == 0) cp = code_point_t'($urandom_range(0, 1) ? lo : hi);
      // steer clear of the surrogate block in well-formed units
      if (len == 3 && cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h2000;
      case (len)
        1: seq[0] = {1'b0, cp[6:0]};
        2: begin
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
        end
        3: begin
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
        end
        default: begin
          seq[0] = {5'b11110, cp[20:18]};
          seq[1] = {2'b10, cp[17:12]};
          seq[2] = {2'b10, cp[11:6]};
          seq[3] = {2'b10, cp[5:0]};
        end
      endcase
      n = len;
      // truncated: the next unit's lead lands where a continuation belongs
      if (kind == 12) n = $urandom_range(1, len - 1);
    end else if (kind == 13) begin
      n = 1;
      seq[0] = 8'($urandom_range(0, 255));
    end else if (kind == 14) begin
      // any lead with continuations: overlong, surrogate, beyond range
      n = $urandom_range(2, 4);
      seq[0] = 8'($urandom_range('hC0, 'hFF));
      for (int i = 1; i < 4; i++) seq[i] = 8'($urandom_range('h80, 'hBF));
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) seq[i] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < n; i++) begin
      send_byte(seq[i], (i == 0) ? first_ts : (kind == 15 && $urandom_range(0, 7) == 0));
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: random back-pressure, one long hold-off partway through
  // ---------------------------------------------------------------------
  initial begin
    int  r;
    logic held;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && beats_out >= HOLD_AFTER) begin
        // decoder fills up and must stall its input while the sender keeps going
        held = 1'b1;
        out_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (burst_mode) begin
        out_if.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_if.ready = 1'b0;
          repeat ($urandom_range(5, 30)) @(negedge clk);
        end else begin
          out_if.ready = (r >= 25);
        end
      end
    end
  end

  // result beats checked at the rising edge where they are taken
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_result(out_if.code_point, status_t'(out_if.status));
      beats_out <= beats_out + 1;
    end
  end

  // watchdog: stops a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("utf8_byte_stream_decoder_top_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    sb = new();
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.text_start = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);
    while (sb.n_bytes < TOTAL_BYTES) send_unit();
    in_if.valid = 1'b0;

    // drain, then wait for stray result beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("decoded %0d bytes in %0d cycles: %0d code points, %0d invalid beats",
             sb.n_bytes, cycles, sb.n_done, sb.n_invalid);
    $display("%0d restarts by text_start, long output hold-off of %0d cycles",
             sb.n_restarts, LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("utf8_byte_stream_decoder_top_test passed");
    end else begin
      $display("utf8_byte_stream_decoder_top_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
